// ===== src/fte_pkg.sv =====
// ----------------------------------------------------------------------------
// fte_pkg
// Shared types and constants of the packed 12-bit allocation table engine.
// ----------------------------------------------------------------------------
package fte_pkg;

  // Internal byte address: wide enough for base + 1 of any entry the free
  // count can step to (entry counter is one bit wider than entry_index).
  localparam int unsigned NADDR_W   = 14;
  localparam int unsigned ENTRY_N_W = 13;
  localparam int unsigned COUNT_W   = 12;

  localparam logic [COUNT_W-1:0]   CLUSTER_COUNT_RESET = 12'd2847;
  localparam logic [ENTRY_N_W-1:0] FIRST_DATA_ENTRY    = 13'd2;

  typedef enum logic [2:0] {
    CMD_LOAD_BYTE   = 3'd0,
    CMD_READ_BYTE   = 3'd1,
    CMD_READ_ENTRY  = 3'd2,
    CMD_WRITE_ENTRY = 3'd3,
    CMD_COUNT_FREE  = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_BYTE_RD,
    ST_ENT_LO,
    ST_ENT_HI,
    ST_WR_RD,
    ST_WR_NB,
    ST_WR_OT,
    ST_CNT_LO,
    ST_CNT_HI,
    ST_CNT_EV,
    ST_RESULT
  } state_e;

  // Byte address source for the table access of one cycle.
  typedef enum logic [2:0] {
    ADDR_BYTE,   // raw byte address of the item
    ADDR_LO,     // first byte of the entry
    ADDR_HI,     // second byte of the entry
    ADDR_NB,     // byte shared with the neighbor entry
    ADDR_OT      // byte owned by the entry alone
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_BYTE,
    WD_NEIGHBOR,
    WD_OTHER
  } wdata_sel_e;

  typedef struct packed {
    logic [2:0]  command;
    logic        copy_select;
    logic [12:0] byte_address;
    logic [7:0]  byte_value;
    logic [11:0] entry_index;
    logic [11:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [11:0] entry_read;
    logic [7:0]  byte_read;
    logic [11:0] free_count;
  } out_item_t;

  typedef struct packed {
    logic       load_item;
    addr_sel_e  addr_sel;
    logic       rd;
    logic       we;
    wdata_sel_e wdata_sel;
    logic       cap_lo;
    logic       cnt_step;
    logic       push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_end;
  } dp_status_t;

endpackage

// ===== src/fat12_table_engine_top.sv =====
// ----------------------------------------------------------------------------
// fat12_table_engine_top
// Packed 12-bit allocation table with primary and mirror byte stores.
// ----------------------------------------------------------------------------
//
//   channel | signals                               | direction | transfer when
//   --------+---------------------------------------+-----------+----------------------
//   in      | in_valid_i, in_stall_o, in_data_i     | into      | valid && !stall
//   out     | out_valid_o, out_stall_i, out_data_o  | out of    | valid && !stall
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_data_i  | into      | valid && ready
//
// One word at a time: a new input word is taken only in idle, once the
// result word of the last one has gone into the output register. A free
// count examines the entries one after another, up to the count limit or
// the end of the store. Each store has one port, so the sequencer spends
// one state per byte access.
// Reset clears the sequencer, the output valid and cluster_count (2847); the
// stores are not cleared and need no clearing pass.
// A stalled result word holds in the output register while the next input
// word is taken; that word's result waits until the register frees up.
//
module fat12_table_engine_top #(
  parameter int unsigned TABLE_BYTES = 4608
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fte_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fte_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [11:0]        cfg_data_i
);
  import fte_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The user is to change the configuration only while idle; the block does not enforce it and always takes the word.
  assign cfg_ready_o = 1'b1;

  // Sequence the byte accesses of each command.
  fte_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // Hold the stores, pack and unpack entries, count free entries.
  fte_datapath #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

// ===== src/fte_datapath.sv =====
// ----------------------------------------------------------------------------
// fte_datapath
// Table stores, entry packing and unpacking, free counter and result register.
// ----------------------------------------------------------------------------
module fte_datapath #(
  parameter int unsigned TABLE_BYTES = 4608
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fte_pkg::in_item_t  in_data_i,
  input  logic               cfg_we_i,
  input  logic [11:0]        cfg_data_i,
  input  fte_pkg::ctrl_cmd_t cmd_i,
  output fte_pkg::dp_status_t status_o,
  output fte_pkg::out_item_t out_data_o
);
  import fte_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_BYTES);

  function automatic logic [11:0] entry_join(input logic [7:0] lo, input logic [7:0] hi,
                                             input logic odd);
    return odd ? {hi, lo[7:4]} : {hi[3:0], lo};
  endfunction

  function automatic logic [7:0] nb_merge(input logic [7:0] old, input logic [11:0] v,
                                          input logic odd);
    return odd ? {v[3:0], old[3:0]} : {old[7:4], v[11:8]};
  endfunction

  logic [7:0] pri_mem [TABLE_BYTES];
  logic [7:0] mir_mem [TABLE_BYTES];

  in_item_t             item_q;
  logic [ENTRY_N_W-1:0] n_q;
  logic [COUNT_W-1:0]   k_q;
  logic [COUNT_W-1:0]   cnt_q;
  logic [7:0]           lo_q;
  logic                 rin_q;
  logic [7:0]           pri_rd_q;
  logic [7:0]           mir_rd_q;
  logic [COUNT_W-1:0]   cluster_count_q;
  out_item_t            out_q;

  logic [NADDR_W-1:0] base;
  logic [NADDR_W-1:0] base_p1;
  logic [NADDR_W-1:0] addr;
  logic [AW-1:0]      idx;
  logic               odd;
  logic               in_range;
  logic               pri_we;
  logic               mir_we;
  logic               rd_en;
  logic [7:0]         pri_wdata;
  logic [7:0]         mir_wdata;
  logic [7:0]         ot_byte;
  logic [11:0]        cnt_entry;
  out_item_t          res;

  assign odd     = n_q[0];
  assign base    = NADDR_W'(n_q) + NADDR_W'(n_q[ENTRY_N_W-1:1]);
  assign base_p1 = base + NADDR_W'(1);

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_BYTE: addr = NADDR_W'(item_q.byte_address);
      ADDR_LO:   addr = base;
      ADDR_HI:   addr = base_p1;
      ADDR_NB:   addr = odd ? base : base_p1;
      ADDR_OT:   addr = odd ? base_p1 : base;
      default:   addr = base;
    endcase
  end

  assign in_range = addr < NADDR_W'(TABLE_BYTES);
  assign idx      = addr[AW-1:0];
  assign rd_en    = cmd_i.rd && in_range;
  assign pri_we   = cmd_i.we && in_range &&
                    ((cmd_i.wdata_sel != WD_BYTE) || !item_q.copy_select);
  assign mir_we   = cmd_i.we && in_range &&
                    ((cmd_i.wdata_sel != WD_BYTE) || item_q.copy_select);
  assign ot_byte  = odd ? item_q.entry_value[11:4] : item_q.entry_value[7:0];

  always_comb begin
    case (cmd_i.wdata_sel)
      WD_BYTE: begin
        pri_wdata = item_q.byte_value;
        mir_wdata = item_q.byte_value;
      end
      WD_NEIGHBOR: begin
        pri_wdata = nb_merge(pri_rd_q, item_q.entry_value, odd);
        mir_wdata = nb_merge(mir_rd_q, item_q.entry_value, odd);
      end
      WD_OTHER: begin
        pri_wdata = ot_byte;
        mir_wdata = ot_byte;
      end
      default: begin
        pri_wdata = ot_byte;
        mir_wdata = ot_byte;
      end
    endcase
  end

  // Single-port stores, registered read data.
  always_ff @(posedge clk_i) begin
    if (pri_we) begin
      pri_mem[idx] <= pri_wdata;
    end else if (rd_en) begin
      pri_rd_q <= pri_mem[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mir_we) begin
      mir_mem[idx] <= mir_wdata;
    end else if (rd_en) begin
      mir_rd_q <= mir_mem[idx];
    end
  end

  assign cnt_entry = entry_join(lo_q, pri_rd_q, odd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rin_q           <= 1'b0;
      cluster_count_q <= CLUSTER_COUNT_RESET;
    end else begin
      if (cmd_i.rd) begin
        rin_q <= in_range;
      end
      if (cfg_we_i) begin
        cluster_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
      n_q    <= (cmd_e'(in_data_i.command) == CMD_COUNT_FREE) ? FIRST_DATA_ENTRY
                                                              : ENTRY_N_W'(in_data_i.entry_index);
      k_q    <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.cnt_step) begin
      n_q <= n_q + ENTRY_N_W'(1);
      k_q <= k_q + COUNT_W'(1);
      if (cnt_entry == 12'd0) begin
        cnt_q <= cnt_q + COUNT_W'(1);
      end
    end
    if (cmd_i.cap_lo) begin
      lo_q <= rin_q ? pri_rd_q : 8'd0;
    end
    if (cmd_i.push) begin
      out_q <= res;
    end
  end

  always_comb begin
    res = '0;
    case (cmd_e'(item_q.command))
      CMD_READ_BYTE: begin
        res.byte_read = rin_q ? (item_q.copy_select ? mir_rd_q : pri_rd_q) : 8'd0;
      end
      CMD_READ_ENTRY: begin
        res.entry_read = entry_join(lo_q, rin_q ? pri_rd_q : 8'd0, odd);
      end
      CMD_COUNT_FREE: begin
        res.free_count = cnt_q;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Stop the walk at the count limit or when the entry's second byte leaves
  // the store.
  assign status_o.cnt_end = (k_q == cluster_count_q) || (base_p1 >= NADDR_W'(TABLE_BYTES));
  assign out_data_o       = out_q;

endmodule

// ===== src/fte_ctrl.sv =====
// ----------------------------------------------------------------------------
// fte_ctrl
// Command sequencer: at most one table access per state, output word handshake.
// ----------------------------------------------------------------------------
module fte_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [2:0]          in_command_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  fte_pkg::dp_status_t status_i,
  output fte_pkg::ctrl_cmd_t  cmd_o
);
  import fte_pkg::*;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   slot_free;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd_e'(in_command_i))
            CMD_LOAD_BYTE:   state_d = ST_LOAD_WR;
            CMD_READ_BYTE:   state_d = ST_BYTE_RD;
            CMD_READ_ENTRY:  state_d = ST_ENT_LO;
            CMD_WRITE_ENTRY: state_d = ST_WR_RD;
            CMD_COUNT_FREE:  state_d = ST_CNT_LO;
            default:         state_d = ST_RESULT;
          endcase
        end
      end
      ST_LOAD_WR: state_d = ST_RESULT;
      ST_BYTE_RD: state_d = ST_RESULT;
      ST_ENT_LO:  state_d = ST_ENT_HI;
      ST_ENT_HI:  state_d = ST_RESULT;
      ST_WR_RD:   state_d = ST_WR_NB;
      ST_WR_NB:   state_d = ST_WR_OT;
      ST_WR_OT:   state_d = ST_RESULT;
      ST_CNT_LO:  state_d = status_i.cnt_end ? ST_RESULT : ST_CNT_HI;
      ST_CNT_HI:  state_d = ST_CNT_EV;
      ST_CNT_EV:  state_d = ST_CNT_LO;
      ST_RESULT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.addr_sel  = ADDR_LO;
    cmd_o.wdata_sel = WD_BYTE;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load_item = in_valid_i;
      end
      ST_LOAD_WR: begin
        cmd_o.we       = 1'b1;
        cmd_o.addr_sel = ADDR_BYTE;
      end
      ST_BYTE_RD: begin
        cmd_o.rd       = 1'b1;
        cmd_o.addr_sel = ADDR_BYTE;
      end
      ST_ENT_LO: begin
        cmd_o.rd = 1'b1;
      end
      ST_ENT_HI: begin
        cmd_o.rd       = 1'b1;
        cmd_o.addr_sel = ADDR_HI;
        cmd_o.cap_lo   = 1'b1;
      end
      ST_WR_RD: begin
        cmd_o.rd       = 1'b1;
        cmd_o.addr_sel = ADDR_NB;
      end
      ST_WR_NB: begin
        cmd_o.we        = 1'b1;
        cmd_o.addr_sel  = ADDR_NB;
        cmd_o.wdata_sel = WD_NEIGHBOR;
      end
      ST_WR_OT: begin
        cmd_o.we        = 1'b1;
        cmd_o.addr_sel  = ADDR_OT;
        cmd_o.wdata_sel = WD_OTHER;
      end
      ST_CNT_LO: begin
        cmd_o.rd = !status_i.cnt_end;
      end
      ST_CNT_HI: begin
        cmd_o.rd       = 1'b1;
        cmd_o.addr_sel = ADDR_HI;
        cmd_o.cap_lo   = 1'b1;
      end
      ST_CNT_EV: begin
        cmd_o.cnt_step = 1'b1;
      end
      ST_RESULT: begin
        cmd_o.push = slot_free;
      end
      default: begin
        cmd_o.push = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_push_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> (!out_valid_q || !out_stall_i))
    else $error("result word pushed over a waiting word");

  a_push_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |=> out_valid_q)
    else $error("pushed result word not presented");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("accepted word left sequencer idle");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packed 12-bit allocation table engine.
//
// Load the head and the tail of both table copies with byte loads, run a
// directed set of corner words, then run random phases under several
// cluster_count settings. Each accepted command word updates a local image of
// both tables and yields the expected result word, which is compared field by
// field with the block's output.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fte_pkg::*;

  localparam int unsigned TABLE_BYTES  = 4608;
  localparam int unsigned ENTRY_SPAN   = TABLE_BYTES * 2 / 3;  // entries fully in the store
  localparam int unsigned LOW_BYTES    = 240;                  // loaded head of each copy
  localparam int unsigned TAIL_BYTES   = 24;                   // loaded end of each copy
  localparam int unsigned TAIL_FROM    = TABLE_BYTES - TAIL_BYTES;
  localparam int unsigned LOW_ENTRIES  = LOW_BYTES * 2 / 3;    // entries fully in the head
  localparam int unsigned TAIL_ENTRY   = TAIL_FROM * 2 / 3;    // first entry fully in the tail
  localparam int unsigned FILL_WORDS   = 2 * (LOW_BYTES + TAIL_BYTES);
  localparam int unsigned PHASE_WORDS  = 130;
  localparam int unsigned IDLE_PCT     = 12;
  localparam int unsigned PRESSURE_AT  = 200;                  // during the fill
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned QUIET_FROM   = FILL_WORDS + 100;
  localparam int unsigned QUIET_LEN    = 300;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned SETTLE       = 16;
  localparam int unsigned SHOWN_ERRORS = 10;

  // Command codes the block does not decode.
  localparam logic [2:0] CMD_UNUSED_LO = CMD_COUNT_FREE + 3'd1;
  localparam logic [2:0] CMD_UNUSED_HI = 3'h7;

  // Settings of the register that keep the free count inside the loaded head.
  localparam logic [11:0] SCAN_NONE = 12'd0;
  localparam logic [11:0] SCAN_ONE  = 12'd1;
  localparam logic [11:0] SCAN_HEAD = 12'(LOW_ENTRIES - 2);

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [11:0] cfg_data_i  = '0;

  fat12_table_engine_top #(
    .TABLE_BYTES(TABLE_BYTES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Table image and expected results
  // --------------------------------------------------------------------------
  // Copy 0 is the primary table, copy 1 the mirror.
  logic [7:0]  fat_img [2][TABLE_BYTES];
  logic [11:0] scan_len = CLUSTER_COUNT_RESET;

  in_item_t    cmd_backlog [$];   // command words not yet offered
  out_item_t   answers_due [$];   // result words owed by the block

  int unsigned n_in       = 0;    // command words accepted
  int unsigned n_out      = 0;    // result words accepted
  int unsigned mismatches = 0;
  int unsigned cmd_tally [8];
  int unsigned cfg_writes = 0;
  int unsigned cycles     = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;
  logic        quiet;

  // No random idling on either side inside this window of accepted words.
  assign quiet = (n_in >= QUIET_FROM) && (n_in < QUIET_FROM + QUIET_LEN);

  function automatic logic [7:0] img_rd(bit cp, int unsigned addr);
    return (addr < TABLE_BYTES) ? fat_img[cp][addr] : 8'h00;
  endfunction

  function automatic void img_wr(bit cp, int unsigned addr, logic [7:0] val);
    if (addr < TABLE_BYTES) fat_img[cp][addr] = val;
  endfunction

  // Entry n starts at byte 3n/2; even entries own the low byte, odd ones the
  // high byte, and the middle nibbles are shared.
  function automatic logic [11:0] entry_rd(bit cp, int unsigned n);
    int unsigned base;
    logic [7:0]  lo;
    logic [7:0]  hi;
    base = 3 * n / 2;
    lo   = img_rd(cp, base);
    hi   = img_rd(cp, base + 1);
    return (n % 2 == 1) ? {hi, lo[7:4]} : {hi[3:0], lo};
  endfunction

  function automatic void entry_wr(bit cp, int unsigned n, logic [11:0] val);
    int unsigned base;
    logic [7:0]  nb;
    base = 3 * n / 2;
    if (n % 2 == 0) begin
      nb = img_rd(cp, base + 1);
      img_wr(cp, base + 1, {nb[7:4], val[11:8]});
      img_wr(cp, base, val[7:0]);
    end else begin
      nb = img_rd(cp, base);
      img_wr(cp, base, {val[3:0], nb[3:0]});
      img_wr(cp, base + 1, val[11:4]);
    end
  endfunction

  // Apply one command word to the image and return the result it owes.
  function automatic out_item_t fat_step(in_item_t w);
    out_item_t   r;
    int unsigned n;
    logic [11:0] free_n;
    r      = '0;
    free_n = '0;
    cmd_tally[w.command]++;
    case (w.command)
      CMD_LOAD_BYTE:   img_wr(w.copy_select, w.byte_address, w.byte_value);
      CMD_READ_BYTE:   r.byte_read = img_rd(w.copy_select, w.byte_address);
      CMD_READ_ENTRY:  r.entry_read = entry_rd(1'b0, w.entry_index);
      CMD_WRITE_ENTRY: begin
        entry_wr(1'b0, w.entry_index, w.entry_value);
        entry_wr(1'b1, w.entry_index, w.entry_value);
      end
      CMD_COUNT_FREE: begin
        // Stop at the first entry whose second byte falls off the store.
        for (int unsigned k = 0; k < scan_len; k++) begin
          n = FIRST_DATA_ENTRY + k;
          if (3 * n / 2 + 1 >= TABLE_BYTES) break;
          if (entry_rd(1'b0, n) == 12'h000) free_n++;
        end
        r.free_count = free_n;
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Word builders
  // --------------------------------------------------------------------------
  function automatic in_item_t word(logic [2:0] c, logic cp, logic [12:0] addr,
                                    logic [7:0] bv, logic [11:0] idx,
                                    logic [11:0] ev);
    in_item_t w;
    w.command      = c;
    w.copy_select  = cp;
    w.byte_address = addr;
    w.byte_value   = bv;
    w.entry_index  = idx;
    w.entry_value  = ev;
    return w;
  endfunction

  // Randomize every field, so that fields the command ignores toggle too.
  // Bias toward zero values to keep free entries around. Addresses and
  // indexes land in the loaded head, in the loaded tail, or past the store.
  function automatic in_item_t rand_word(logic [2:0] c);
    in_item_t    w;
    int unsigned roll;
    w.command     = c;
    w.copy_select = 1'($urandom_range(1));
    roll = $urandom_range(99);
    if (roll < 8)       w.byte_address = 13'($urandom_range(8191, TABLE_BYTES));
    else if (roll < 18) w.byte_address = 13'($urandom_range(TABLE_BYTES - 1, TAIL_FROM));
    else                w.byte_address = 13'($urandom_range(LOW_BYTES - 1));
    w.byte_value  = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
    roll = $urandom_range(99);
    if (roll < 8)       w.entry_index = 12'($urandom_range(4095, ENTRY_SPAN));
    else if (roll < 18) w.entry_index = 12'($urandom_range(ENTRY_SPAN - 1, TAIL_ENTRY));
    else                w.entry_index = 12'($urandom_range(LOW_ENTRIES - 1));
    w.entry_value = ($urandom_range(3) == 0) ? 12'h000 : 12'($urandom);
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, cycle limit, receiver hold-off
  // --------------------------------------------------------------------------
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles: %0d words in, %0d results out, %0d owed",
               cycles, n_in, n_out, answers_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Hold the receiver off once for a long stretch while the fill keeps
  // offering words, so the block backs up and stalls its input.
  always @(posedge clk_i) begin
    if (!hold_done && n_in == PRESSURE_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: offer backlog words, hold a word until it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        answers_due.push_back(fat_step(in_data_i));
        n_in <= n_in + 1;
      end
      // Advance only when the current slot is empty or was just taken.
      if (!in_valid_i || !in_stall_o) begin
        if (cmd_backlog.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= cmd_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result word against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_out <= n_out + 1;
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("[%0t] result word with nothing owed: entry %h byte %h free %0d",
                     $realtime, out_data_o.entry_read, out_data_o.byte_read,
                     out_data_o.free_count);
        end else begin
          want = answers_due.pop_front();
          if (out_data_o.entry_read !== want.entry_read ||
              out_data_o.byte_read  !== want.byte_read  ||
              out_data_o.free_count !== want.free_count) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
              $display({"[%0t] result %0d mismatch: entry %h/%h byte %h/%h ",
                        "free %0d/%0d (expected/actual)"},
                       $realtime, n_out, want.entry_read, out_data_o.entry_read,
                       want.byte_read, out_data_o.byte_read,
                       want.free_count, out_data_o.free_count);
          end
        end
      end
      out_stall_i <= (hold_left != 0) || (!quiet && $urandom_range(99) < IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  // Wait until every word is taken and every result has come back.
  task automatic drain();
    do @(posedge clk_i);
    while (cmd_backlog.size() != 0 || in_valid_i || answers_due.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_scan_len(logic [11:0] val);
    drain();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    scan_len = val;
    cfg_writes++;
  endtask

  // Entry writes followed by a read of the same or the neighbor entry, mixed
  // with raw byte traffic, lone entry reads and writes, free counts and undecoded commands.
  task automatic run_random(int unsigned count);
    in_item_t    w;
    in_item_t    rb;
    int unsigned roll;
    int unsigned made;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        w  = rand_word(CMD_WRITE_ENTRY);
        rb = rand_word(CMD_READ_ENTRY);
        rb.entry_index = w.entry_index ^ 12'($urandom_range(3) == 0);
        cmd_backlog.push_back(w);
        cmd_backlog.push_back(rb);
        made += 2;
      end else begin
        if      (roll < 45) w = rand_word(CMD_LOAD_BYTE);
        else if (roll < 60) w = rand_word(CMD_READ_BYTE);
        else if (roll < 78) w = rand_word(CMD_READ_ENTRY);
        else if (roll < 93) w = rand_word(CMD_WRITE_ENTRY);
        else if (roll < 96) w = rand_word(CMD_COUNT_FREE);
        else                w = rand_word(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)));
        cmd_backlog.push_back(w);
        made++;
      end
    end
    // Close each phase with a count under its setting.
    cmd_backlog.push_back(rand_word(CMD_COUNT_FREE));
  endtask

  initial begin
    in_item_t    w;
    logic [11:0] scan_plan [6];
    int unsigned a;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Load the head and the tail of both copies; every later word touches
    // only loaded bytes or bytes past the store. Half the bytes are zero to
    // leave plenty of free entries.
    for (int cp = 0; cp < 2; cp++) begin
      for (int unsigned i = 0; i < LOW_BYTES + TAIL_BYTES; i++) begin
        a = (i < LOW_BYTES) ? i : TAIL_FROM + i - LOW_BYTES;
        w = rand_word(CMD_LOAD_BYTE);
        w.copy_select  = cp[0];
        w.byte_address = 13'(a);
        w.byte_value   = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom);
        cmd_backlog.push_back(w);
      end
    end
    drain();

    // Directed corners.
    cmd_backlog.push_back(word(CMD_LOAD_BYTE,   1'b0, 13'd0,    8'hFF, 12'd0,    12'h000));
    cmd_backlog.push_back(word(CMD_LOAD_BYTE,   1'b1, 13'd4607, 8'h00, 12'd0,    12'h000));
    // Load past the store: drop it.
    cmd_backlog.push_back(word(CMD_LOAD_BYTE,   1'b0, 13'd4608, 8'hA5, 12'd0,    12'h000));
    cmd_backlog.push_back(word(CMD_READ_BYTE,   1'b0, 13'd0,    8'h00, 12'd0,    12'h000));
    cmd_backlog.push_back(word(CMD_READ_BYTE,   1'b1, 13'd4607, 8'h00, 12'd0,    12'h000));
    cmd_backlog.push_back(word(CMD_READ_BYTE,   1'b0, 13'd4608, 8'h00, 12'd0,    12'h000));
    cmd_backlog.push_back(word(CMD_READ_BYTE,   1'b1, 13'd8191, 8'h00, 12'd0,    12'h000));
    // Even and odd entries sharing byte 1, checked in both copies.
    cmd_backlog.push_back(word(CMD_WRITE_ENTRY, 1'b0, 13'd0,    8'h00, 12'd0,    12'hFFF));
    cmd_backlog.push_back(word(CMD_WRITE_ENTRY, 1'b0, 13'd0,    8'h00, 12'd1,    12'h000));
    cmd_backlog.push_back(word(CMD_READ_ENTRY,  1'b0, 13'd0,    8'h00, 12'd0,    12'h000));
    cmd_backlog.push_back(word(CMD_READ_ENTRY,  1'b0, 13'd0,    8'h00, 12'd1,    12'h000));
    cmd_backlog.push_back(word(CMD_READ_BYTE,   1'b1, 13'd1,    8'h00, 12'd0,    12'h000));
    // Last entry inside the store, then entries wholly past it.
    cmd_backlog.push_back(word(CMD_WRITE_ENTRY, 1'b0, 13'd0,    8'h00, 12'd3071, 12'hABC));
    cmd_backlog.push_back(word(CMD_READ_ENTRY,  1'b0, 13'd0,    8'h00, 12'd3071, 12'h000));
    cmd_backlog.push_back(word(CMD_READ_BYTE,   1'b1, 13'd4606, 8'h00, 12'd0,    12'h000));
    cmd_backlog.push_back(word(CMD_WRITE_ENTRY, 1'b0, 13'd0,    8'h00, 12'd3072, 12'h123));
    cmd_backlog.push_back(word(CMD_READ_ENTRY,  1'b0, 13'd0,    8'h00, 12'd3072, 12'h000));
    cmd_backlog.push_back(word(CMD_WRITE_ENTRY, 1'b0, 13'd0,    8'h00, 12'd4095, 12'hFFF));
    cmd_backlog.push_back(word(CMD_READ_ENTRY,  1'b0, 13'd0,    8'h00, 12'd4095, 12'h000));
    cmd_backlog.push_back(word(CMD_UNUSED_LO,   1'b1, 13'd8191, 8'hFF, 12'hFFF,  12'hFFF));
    cmd_backlog.push_back(word(CMD_UNUSED_HI,   1'b0, 13'd0,    8'h00, 12'd0,    12'h000));

    // One random phase per cluster_count setting; set_scan_len drains first.
    scan_plan[0] = SCAN_NONE;
    scan_plan[1] = SCAN_HEAD;
    scan_plan[2] = SCAN_ONE;
    scan_plan[3] = 12'($urandom_range(SCAN_HEAD, 2));
    scan_plan[4] = 12'($urandom_range(64, 2));
    scan_plan[5] = 12'($urandom_range(SCAN_HEAD));
    foreach (scan_plan[i]) begin
      set_scan_len(scan_plan[i]);
      run_random(PHASE_WORDS);
    end
    drain();

    $display({"Run covered %0d words: %0d byte loads, %0d byte reads, %0d entry reads, ",
              "%0d entry writes, %0d free counts, %0d undecoded."},
             n_in, cmd_tally[CMD_LOAD_BYTE], cmd_tally[CMD_READ_BYTE],
             cmd_tally[CMD_READ_ENTRY], cmd_tally[CMD_WRITE_ENTRY],
             cmd_tally[CMD_COUNT_FREE],
             cmd_tally[CMD_UNUSED_LO] + cmd_tally[CMD_UNUSED_LO + 3'd1] +
             cmd_tally[CMD_UNUSED_HI]);
    $display({"cluster_count written %0d times (0, 1 and %0d among them), ",
              "%0d result mismatches."},
             cfg_writes, SCAN_HEAD, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/fte_pkg.sv
src/fte_datapath.sv
src/fte_ctrl.sv
src/fat12_table_engine_top.sv
tb/sv/tb_top.sv
